// File: rtl/gbds_pkg.sv
package gbds_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int MASK_W   = 4;
   localparam int TAG_W    = 16;
   localparam int WORD_W   = 64;
   localparam int WNUM_W   = 10;
   localparam int COUNT_W  = 17;
   localparam int SUM_W    = 18;
   localparam int SQUARE_W = 19;
   localparam int MEAN_W   = 18;
   localparam int CSQ_W    = 33;

   // packing: four individuals per byte, sixteen bytes per word
   localparam int INDIV_PER_BYTE = 4;
   localparam int SLOT_W         = 4;
   localparam int SLOT_LAST      = WORD_W / INDIV_PER_BYTE - 1;

   // word numbers wrap at 2^WNUM_W at most
   localparam int WNUM_SPAN = 1 << WNUM_W;

   // summary arithmetic
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = COUNT_W + SQUARE_W;
   localparam int DIV_W     = PROD_W + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // defaults for top level parameters
   localparam int MAX_WORDS_DEF   = 1024;
   localparam int QUEUE_DEPTH_DEF = 4;

   // 2-bit genotype codes
   localparam logic [1:0] CODE_HOM_A   = 2'b00;
   localparam logic [1:0] CODE_MISSING = 2'b01;
   localparam logic [1:0] CODE_HET     = 2'b10;
   localparam logic [1:0] CODE_HOM_B   = 2'b11;

   // result kinds
   localparam logic KIND_WORD    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // one finished word, plus the SNP totals when it closes the SNP
   typedef struct packed {
      logic [WORD_W-1:0]   plane_one;
      logic [WORD_W-1:0]   plane_two;
      logic [WNUM_W-1:0]   word_number;
      logic [TAG_W-1:0]    tag;
      logic                last;
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    sum;
      logic [SQUARE_W-1:0] square;
   } entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIFF,
      BK_CHECK,
      BK_DIV_MEAN,
      BK_DIV_CSQ,
      BK_EMIT
   } back_state_type;

endpackage

// File: rtl/gbds_front.sv
module gbds_front #(
   parameter int MAX_WORDS = gbds_pkg::MAX_WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [gbds_pkg::BYTE_W-1:0]     genotype_byte,
   input  logic [gbds_pkg::MASK_W-1:0]     valid_mask,
   input  logic                            swap_alleles,
   input  logic [gbds_pkg::TAG_W-1:0]      snp_tag,
   input  logic                            last_byte,
   output logic                            entry_push,
   output gbds_pkg::entry_type             entry
);

   localparam int WRAP_AT = (MAX_WORDS > gbds_pkg::WNUM_SPAN) ?
                            gbds_pkg::WNUM_SPAN : MAX_WORDS;
   localparam logic [gbds_pkg::WNUM_W-1:0] WORD_LAST = gbds_pkg::WNUM_W'(WRAP_AT - 1);
   localparam logic [gbds_pkg::SLOT_W-1:0] SLOT_END  = gbds_pkg::SLOT_W'(gbds_pkg::SLOT_LAST);

   logic [gbds_pkg::WORD_W-1:0]   plane_one_ff, plane_one_in;
   logic [gbds_pkg::WORD_W-1:0]   plane_two_ff, plane_two_in;
   logic [gbds_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [gbds_pkg::WNUM_W-1:0]   word_cnt_ff, word_cnt_in;
   logic [gbds_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [gbds_pkg::SQUARE_W-1:0] square_ff, square_in;
   logic [gbds_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic [3:0] p1, p2;
   logic [2:0] het, hom, pres;
   logic [3:0] dose_add;
   logic [4:0] sq_add;
   logic [gbds_pkg::SUM_W:0]    sum_wide;
   logic [gbds_pkg::SQUARE_W:0] square_wide;
   logic [gbds_pkg::COUNT_W:0]  count_wide;
   logic [gbds_pkg::SUM_W-1:0]    sum_sat;
   logic [gbds_pkg::SQUARE_W-1:0] square_sat;
   logic [gbds_pkg::COUNT_W-1:0]  count_sat;
   logic [gbds_pkg::WORD_W-1:0]   plane_one_new, plane_two_new;
   logic [gbds_pkg::WNUM_W-1:0]   word_cnt_next;
   logic                          word_done;

   // decode four codes; swap mirrors the homozygotes
   always_comb begin
      logic a1, a2;
      p1   = '0;
      p2   = '0;
      het  = '0;
      hom  = '0;
      pres = '0;
      for (int k = 0; k < gbds_pkg::INDIV_PER_BYTE; k++) begin
         unique case (genotype_byte[2*k +: 2])
            gbds_pkg::CODE_HOM_A: begin
               a1 = !swap_alleles;
               a2 = !swap_alleles;
            end
            gbds_pkg::CODE_HET: begin
               a1 = 1'b0;
               a2 = 1'b1;
            end
            gbds_pkg::CODE_HOM_B: begin
               a1 = swap_alleles;
               a2 = swap_alleles;
            end
            gbds_pkg::CODE_MISSING: begin
               a1 = 1'b1;
               a2 = 1'b0;
            end
            default: begin
               a1 = 1'b1;
               a2 = 1'b0;
            end
         endcase
         p1[k] = a1;
         p2[k] = a2;
         if (valid_mask[k]) begin
            if (!a1 && a2) het = het + 3'd1;
            if (a1 && a2) hom = hom + 3'd1;
            if (!a1 || a2) pres = pres + 3'd1;
         end
      end
   end

   assign dose_add = 4'(het) + {hom, 1'b0};
   assign sq_add   = 5'(het) + {hom, 2'b00};

   // saturating totals
   assign sum_wide    = {1'b0, sum_ff} + (gbds_pkg::SUM_W+1)'(dose_add);
   assign square_wide = {1'b0, square_ff} + (gbds_pkg::SQUARE_W+1)'(sq_add);
   assign count_wide  = {1'b0, count_ff} + (gbds_pkg::COUNT_W+1)'(pres);
   assign sum_sat    = sum_wide[gbds_pkg::SUM_W] ? '1 : sum_wide[gbds_pkg::SUM_W-1:0];
   assign square_sat = square_wide[gbds_pkg::SQUARE_W] ? '1 :
                       square_wide[gbds_pkg::SQUARE_W-1:0];
   assign count_sat  = count_wide[gbds_pkg::COUNT_W] ? '1 : count_wide[gbds_pkg::COUNT_W-1:0];

   // nibble slot is still clear, so a plain write matches an OR
   always_comb begin
      plane_one_new = plane_one_ff;
      plane_two_new = plane_two_ff;
      plane_one_new[{slot_ff, 2'b00} +: 4] = p1;
      plane_two_new[{slot_ff, 2'b00} +: 4] = p2;
   end

   assign word_done     = (slot_ff == SLOT_END) || last_byte;
   assign word_cnt_next = (word_cnt_ff == WORD_LAST) ? '0 : word_cnt_ff + 1'b1;

   always_comb begin
      plane_one_in = plane_one_ff;
      plane_two_in = plane_two_ff;
      slot_in      = slot_ff;
      word_cnt_in  = word_cnt_ff;
      sum_in       = sum_ff;
      square_in    = square_ff;
      count_in     = count_ff;
      if (accept) begin
         sum_in    = sum_sat;
         square_in = square_sat;
         count_in  = count_sat;
         if (word_done) begin
            plane_one_in = '0;
            plane_two_in = '0;
            slot_in      = '0;
            word_cnt_in  = word_cnt_next;
         end else begin
            plane_one_in = plane_one_new;
            plane_two_in = plane_two_new;
            slot_in      = slot_ff + 1'b1;
         end
         if (last_byte) begin
            word_cnt_in = '0;
            sum_in      = '0;
            square_in   = '0;
            count_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_one_ff <= '0;
         plane_two_ff <= '0;
         slot_ff      <= '0;
         word_cnt_ff  <= '0;
         sum_ff       <= '0;
         square_ff    <= '0;
         count_ff     <= '0;
      end else begin
         plane_one_ff <= plane_one_in;
         plane_two_ff <= plane_two_in;
         slot_ff      <= slot_in;
         word_cnt_ff  <= word_cnt_in;
         sum_ff       <= sum_in;
         square_ff    <= square_in;
         count_ff     <= count_in;
      end
   end

   assign entry_push        = accept && word_done;
   assign entry.plane_one   = plane_one_new;
   assign entry.plane_two   = plane_two_new;
   assign entry.word_number = word_cnt_ff;
   assign entry.tag         = snp_tag;
   assign entry.last        = last_byte;
   assign entry.count       = count_sat;
   assign entry.sum         = sum_sat;
   assign entry.square      = square_sat;

endmodule

// File: rtl/gbds_queue.sv
module gbds_queue #(
   parameter int DEPTH = gbds_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gbds_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output gbds_pkg::entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   gbds_pkg::entry_type store [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_FULL);
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop) rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) store[wr_ptr_ff] <= push_data;
   end

endmodule

// File: rtl/gbds_div.sv
module gbds_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gbds_pkg::DIV_W-1:0]        dividend,
   input  logic [gbds_pkg::COUNT_W-1:0]      divisor,
   output logic                              done,
   output logic [gbds_pkg::DIV_W-1:0]        quotient
);

   // restoring division, one quotient bit per cycle
   localparam int DW = gbds_pkg::DIV_W;
   localparam int NW = gbds_pkg::COUNT_W;
   localparam logic [gbds_pkg::DIV_CNT_W-1:0] STEP_LAST = gbds_pkg::DIV_CNT_W'(DW - 1);

   logic [DW-1:0]                     quo_ff, quo_in;
   logic [NW-1:0]                     rem_ff, rem_in;
   logic [NW-1:0]                     den_ff, den_in;
   logic [gbds_pkg::DIV_CNT_W-1:0]    step_ff, step_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [NW:0]                       shifted;
   logic [NW:0]                       trial;
   logic                              fits;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DW-2:0], fits};
         rem_in  = fits ? trial[NW-1:0] : shifted[NW-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/gbds_back.sv
module gbds_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  gbds_pkg::entry_type                 q_head,
   output logic                                q_pop,
   output logic                                div_start,
   output logic [gbds_pkg::DIV_W-1:0]          div_dividend,
   output logic [gbds_pkg::COUNT_W-1:0]        div_divisor,
   input  logic                                div_done,
   input  logic [gbds_pkg::DIV_W-1:0]          div_quotient,
   input  logic                                pop,
   output logic                                empty,
   output logic                                result_kind,
   output logic [gbds_pkg::WORD_W-1:0]         plane_one_word,
   output logic [gbds_pkg::WORD_W-1:0]         plane_two_word,
   output logic [gbds_pkg::WNUM_W-1:0]         word_number,
   output logic [gbds_pkg::TAG_W-1:0]          tag_out,
   output logic [gbds_pkg::COUNT_W-1:0]        present_count,
   output logic [gbds_pkg::SUM_W-1:0]          allele_total,
   output logic [gbds_pkg::SQUARE_W-1:0]       square_total,
   output logic [gbds_pkg::MEAN_W-1:0]         mean_fixed,
   output logic [gbds_pkg::CSQ_W-1:0]          centered_square_fixed,
   output logic                                usable,
   output logic                                last_result
);

   localparam int DW = gbds_pkg::DIV_W;
   localparam int PW = gbds_pkg::PROD_W;
   localparam int FB = gbds_pkg::FRAC_BITS;

   gbds_pkg::back_state_type state_ff, state_in;

   // SNP totals under work
   logic [gbds_pkg::COUNT_W-1:0]  n_ff, n_in;
   logic [gbds_pkg::SUM_W-1:0]    s_ff, s_in;
   logic [gbds_pkg::SQUARE_W-1:0] ss_ff, ss_in;
   logic [gbds_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic [PW-1:0]                 prod_ff, ssq_ff, diff_ff;
   logic [gbds_pkg::MEAN_W-1:0]   mean_ff, mean_in;
   logic [gbds_pkg::CSQ_W-1:0]    csq_ff, csq_in;
   logic                          ok_ff, ok_in;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic                          r_kind_ff;
   logic [gbds_pkg::WORD_W-1:0]   r_p1_ff, r_p2_ff;
   logic [gbds_pkg::WNUM_W-1:0]   r_wnum_ff;
   logic [gbds_pkg::TAG_W-1:0]    r_tag_ff;
   logic [gbds_pkg::COUNT_W-1:0]  r_count_ff;
   logic [gbds_pkg::SUM_W-1:0]    r_sum_ff;
   logic [gbds_pkg::SQUARE_W-1:0] r_square_ff;
   logic [gbds_pkg::MEAN_W-1:0]   r_mean_ff;
   logic [gbds_pkg::CSQ_W-1:0]    r_csq_ff;
   logic                          r_usable_ff, r_last_ff;

   logic slot_free;
   logic load_word, load_summary;
   logic check_ok;
   logic [gbds_pkg::MEAN_W-1:0] mean_sat;
   logic [gbds_pkg::CSQ_W-1:0]  csq_sat;

   assign slot_free = !out_valid_ff || pop;
   assign check_ok  = (n_ff != '0) && ({diff_ff, 1'b0} >= (PW+1)'(n_ff));
   assign mean_sat  = (|div_quotient[DW-1:gbds_pkg::MEAN_W]) ? '1 :
                      div_quotient[gbds_pkg::MEAN_W-1:0];
   assign csq_sat   = (|div_quotient[DW-1:gbds_pkg::CSQ_W]) ? '1 :
                      div_quotient[gbds_pkg::CSQ_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbds_pkg::BK_IDLE:
            if (!q_empty && slot_free && q_head.last) state_in = gbds_pkg::BK_MUL;
         gbds_pkg::BK_MUL:   state_in = gbds_pkg::BK_DIFF;
         gbds_pkg::BK_DIFF:  state_in = gbds_pkg::BK_CHECK;
         gbds_pkg::BK_CHECK:
            state_in = check_ok ? gbds_pkg::BK_DIV_MEAN : gbds_pkg::BK_EMIT;
         gbds_pkg::BK_DIV_MEAN:
            if (div_done) state_in = gbds_pkg::BK_DIV_CSQ;
         gbds_pkg::BK_DIV_CSQ:
            if (div_done) state_in = gbds_pkg::BK_EMIT;
         gbds_pkg::BK_EMIT:
            if (slot_free) state_in = gbds_pkg::BK_IDLE;
         default: state_in = gbds_pkg::BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop        = 1'b0;
      load_word    = 1'b0;
      load_summary = 1'b0;
      div_start    = 1'b0;
      div_dividend = DW'({s_ff, {FB{1'b0}}});
      unique case (state_ff)
         gbds_pkg::BK_IDLE: begin
            q_pop     = !q_empty && slot_free;
            load_word = !q_empty && slot_free;
         end
         gbds_pkg::BK_CHECK: begin
            div_start = check_ok;
         end
         gbds_pkg::BK_DIV_MEAN: begin
            div_start    = div_done;
            div_dividend = {diff_ff, {FB{1'b0}}};
         end
         gbds_pkg::BK_EMIT: begin
            load_summary = slot_free;
         end
         default: ;
      endcase
   end

   assign div_divisor = n_ff;

   always_comb begin
      n_in    = n_ff;
      s_in    = s_ff;
      ss_in   = ss_ff;
      tag_in  = tag_ff;
      ok_in   = ok_ff;
      mean_in = mean_ff;
      csq_in  = csq_ff;
      if (load_word) begin
         n_in   = q_head.count;
         s_in   = q_head.sum;
         ss_in  = q_head.square;
         tag_in = q_head.tag;
      end
      if (state_ff == gbds_pkg::BK_CHECK) begin
         ok_in   = check_ok;
         mean_in = '0;
         csq_in  = '0;
      end
      if (div_done && state_ff == gbds_pkg::BK_DIV_MEAN) mean_in = mean_sat;
      if (div_done && state_ff == gbds_pkg::BK_DIV_CSQ) csq_in = csq_sat;
   end

   assign out_valid_in = (load_word || load_summary) ? 1'b1 :
                         (pop ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbds_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      s_ff    <= s_in;
      ss_ff   <= ss_in;
      tag_ff  <= tag_in;
      ok_ff   <= ok_in;
      mean_ff <= mean_in;
      csq_ff  <= csq_in;
      if (state_ff == gbds_pkg::BK_MUL) begin
         prod_ff <= PW'(n_ff) * PW'(ss_ff);
         ssq_ff  <= PW'(s_ff) * PW'(s_ff);
      end
      if (state_ff == gbds_pkg::BK_DIFF) begin
         diff_ff <= (prod_ff > ssq_ff) ? prod_ff - ssq_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_word) begin
         r_kind_ff   <= gbds_pkg::KIND_WORD;
         r_p1_ff     <= q_head.plane_one;
         r_p2_ff     <= q_head.plane_two;
         r_wnum_ff   <= q_head.word_number;
         r_tag_ff    <= q_head.tag;
         r_count_ff  <= '0;
         r_sum_ff    <= '0;
         r_square_ff <= '0;
         r_mean_ff   <= '0;
         r_csq_ff    <= '0;
         r_usable_ff <= 1'b0;
         r_last_ff   <= 1'b0;
      end else if (load_summary) begin
         r_kind_ff   <= gbds_pkg::KIND_SUMMARY;
         r_p1_ff     <= '0;
         r_p2_ff     <= '0;
         r_wnum_ff   <= '0;
         r_tag_ff    <= tag_ff;
         r_count_ff  <= ok_ff ? n_ff : '0;
         r_sum_ff    <= s_ff;
         r_square_ff <= ss_ff;
         r_mean_ff   <= mean_ff;
         r_csq_ff    <= csq_ff;
         r_usable_ff <= ok_ff;
         r_last_ff   <= 1'b1;
      end
   end

   assign empty                 = !out_valid_ff;
   assign result_kind           = r_kind_ff;
   assign plane_one_word        = r_p1_ff;
   assign plane_two_word        = r_p2_ff;
   assign word_number           = r_wnum_ff;
   assign tag_out               = r_tag_ff;
   assign present_count         = r_count_ff;
   assign allele_total          = r_sum_ff;
   assign square_total          = r_square_ff;
   assign mean_fixed            = r_mean_ff;
   assign centered_square_fixed = r_csq_ff;
   assign usable                = r_usable_ff;
   assign last_result           = r_last_ff;

endmodule

// File: rtl/genotype_byte_decode_stats_unit.sv
// channel   ports                              direction  handshake
// -------   ---------------------------------  ---------  -----------------------------
// request   req_genotype_byte .. req_last_byte in         push & !full takes an item
// response  rsp_result_kind .. rsp_last_result out        pop & !empty takes an item
//
// Genotype bytes are taken one per cycle while full is low; the front decodes and totals
// them in the cycle they arrive. Word items leave the back at one per cycle while pop is
// high and no summary is in work. A summary takes the back through two multiplies, a
// subtract, a check and, if that passes, two 52-step restoring divisions on the shared
// divider. The front takes bytes until the entry queue fills, then holds full high.
// Synchronous reset clears front totals, queue pointers and valid flag; nothing is swept.

module genotype_byte_decode_stats_unit #(
   parameter int MAX_WORDS   = gbds_pkg::MAX_WORDS_DEF,
   parameter int QUEUE_DEPTH = gbds_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                push,
   output logic                                full,
   input  logic [gbds_pkg::BYTE_W-1:0]         req_genotype_byte,
   input  logic [gbds_pkg::MASK_W-1:0]         req_valid_mask,
   input  logic                                req_swap_alleles,
   input  logic [gbds_pkg::TAG_W-1:0]          req_snp_tag,
   input  logic                                req_last_byte,
   // response side
   output logic                                empty,
   input  logic                                pop,
   output logic                                rsp_result_kind,
   output logic [gbds_pkg::WORD_W-1:0]         rsp_plane_one_word,
   output logic [gbds_pkg::WORD_W-1:0]         rsp_plane_two_word,
   output logic [gbds_pkg::WNUM_W-1:0]         rsp_word_number,
   output logic [gbds_pkg::TAG_W-1:0]          rsp_tag_out,
   output logic [gbds_pkg::COUNT_W-1:0]        rsp_present_count,
   output logic [gbds_pkg::SUM_W-1:0]          rsp_allele_total,
   output logic [gbds_pkg::SQUARE_W-1:0]       rsp_square_total,
   output logic [gbds_pkg::MEAN_W-1:0]         rsp_mean_fixed,
   output logic [gbds_pkg::CSQ_W-1:0]          rsp_centered_square_fixed,
   output logic                                rsp_usable,
   output logic                                rsp_last_result
);

   // full comes straight from the queue, so a byte is only taken
   // when its finished word (if any) has room
   logic                accept;
   logic                entry_push;
   gbds_pkg::entry_type entry;
   logic                q_full, q_empty, q_pop;
   gbds_pkg::entry_type q_head;

   // divider hookup
   logic                               div_start, div_done;
   logic [gbds_pkg::DIV_W-1:0]         div_dividend, div_quotient;
   logic [gbds_pkg::COUNT_W-1:0]       div_divisor;

   assign full   = q_full;
   assign accept = push && !q_full;

   // front: decode codes into bit planes, pack words, keep N/S/SS
   gbds_front #(
      .MAX_WORDS(MAX_WORDS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .genotype_byte(req_genotype_byte),
      .valid_mask   (req_valid_mask),
      .swap_alleles (req_swap_alleles),
      .snp_tag      (req_snp_tag),
      .last_byte    (req_last_byte),
      .entry_push   (entry_push),
      .entry        (entry)
   );

   // finished words, the closing one carrying the SNP totals
   gbds_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (entry_push),
      .push_data(entry),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   // shared divider for the mean and the centered square
   gbds_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   // back: emits words, then works out and emits the summary
   gbds_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_head               (q_head),
      .q_pop                (q_pop),
      .div_start            (div_start),
      .div_dividend         (div_dividend),
      .div_divisor          (div_divisor),
      .div_done             (div_done),
      .div_quotient         (div_quotient),
      .pop                  (pop),
      .empty                (empty),
      .result_kind          (rsp_result_kind),
      .plane_one_word       (rsp_plane_one_word),
      .plane_two_word       (rsp_plane_two_word),
      .word_number          (rsp_word_number),
      .tag_out              (rsp_tag_out),
      .present_count        (rsp_present_count),
      .allele_total         (rsp_allele_total),
      .square_total         (rsp_square_total),
      .mean_fixed           (rsp_mean_fixed),
      .centered_square_fixed(rsp_centered_square_fixed),
      .usable               (rsp_usable),
      .last_result          (rsp_last_result)
   );

endmodule

// File: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gbds_pkg::*;

   // model limits, all-ones of each total and of the fixed point fields
   localparam int COUNT_LIMIT  = (1 << COUNT_W) - 1;
   localparam int SUM_LIMIT    = (1 << SUM_W) - 1;
   localparam int SQUARE_LIMIT = (1 << SQUARE_W) - 1;
   localparam logic [63:0] MEAN_LIMIT = (64'd1 << MEAN_W) - 1;
   localparam logic [63:0] CSQ_LIMIT  = (64'd1 << CSQ_W) - 1;

   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 200;   // room for a late summary to finish
   localparam int LONG_SNP_BYTES = 180;   // eleven full words and a partial one
   localparam int LONG_SNP_CLEAN = 160;   // homozygous, all valid, before the noise tail

   // one result item as the block presents it
   typedef struct {
      logic                kind;
      logic [WORD_W-1:0]   plane_one;
      logic [WORD_W-1:0]   plane_two;
      logic [WNUM_W-1:0]   word_number;
      logic [TAG_W-1:0]    tag;
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    total;
      logic [SQUARE_W-1:0] square;
      logic [MEAN_W-1:0]   mean;
      logic [CSQ_W-1:0]    csq;
      logic                usable;
      logic                last;
   } result_item_type;

   logic clock;
   logic reset;

   logic                push;
   logic                full;
   logic [BYTE_W-1:0]   req_genotype_byte;
   logic [MASK_W-1:0]   req_valid_mask;
   logic                req_swap_alleles;
   logic [TAG_W-1:0]    req_snp_tag;
   logic                req_last_byte;

   logic                empty;
   logic                pop;
   logic                rsp_result_kind;
   logic [WORD_W-1:0]   rsp_plane_one_word;
   logic [WORD_W-1:0]   rsp_plane_two_word;
   logic [WNUM_W-1:0]   rsp_word_number;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic [COUNT_W-1:0]  rsp_present_count;
   logic [SUM_W-1:0]    rsp_allele_total;
   logic [SQUARE_W-1:0] rsp_square_total;
   logic [MEAN_W-1:0]   rsp_mean_fixed;
   logic [CSQ_W-1:0]    rsp_centered_square_fixed;
   logic                rsp_usable;
   logic                rsp_last_result;

   genotype_byte_decode_stats_unit dut (
      .clock                     (clock),
      .reset                     (reset),
      .push                      (push),
      .full                      (full),
      .req_genotype_byte         (req_genotype_byte),
      .req_valid_mask            (req_valid_mask),
      .req_swap_alleles          (req_swap_alleles),
      .req_snp_tag               (req_snp_tag),
      .req_last_byte             (req_last_byte),
      .empty                     (empty),
      .pop                       (pop),
      .rsp_result_kind           (rsp_result_kind),
      .rsp_plane_one_word        (rsp_plane_one_word),
      .rsp_plane_two_word        (rsp_plane_two_word),
      .rsp_word_number           (rsp_word_number),
      .rsp_tag_out               (rsp_tag_out),
      .rsp_present_count         (rsp_present_count),
      .rsp_allele_total          (rsp_allele_total),
      .rsp_square_total          (rsp_square_total),
      .rsp_mean_fixed            (rsp_mean_fixed),
      .rsp_centered_square_fixed (rsp_centered_square_fixed),
      .rsp_usable                (rsp_usable),
      .rsp_last_result           (rsp_last_result)
   );

   // ---------------------------------------------------------------------------------
   // predictor state: one open word per plane plus the running SNP totals
   // ---------------------------------------------------------------------------------
   logic [WORD_W-1:0]   p1_bits;
   logic [WORD_W-1:0]   p2_bits;
   int                  slot_pos;
   int                  word_seq;
   int                  dose_sum;
   int                  dose_square_sum;
   int                  present_n;

   result_item_type pending_results[$];   // expected result items, oldest first

   int  errors;
   int  items_sent;
   int  words_checked;
   int  summaries_checked;
   int  usable_seen;
   int  full_stall_cycles;
   bit  idle_enable;       // random gaps on both sides
   bit  hold_request;      // asks the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous bound on the whole run
   initial begin
      #20_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic void clear_snp_state();
      p1_bits         = '0;
      p2_bits         = '0;
      slot_pos        = 0;
      word_seq        = 0;
      dose_sum        = 0;
      dose_square_sum = 0;
      present_n       = 0;
   endfunction

   function automatic int clamp_total(input int value, input int limit);
      return (value > limit) ? limit : value;
   endfunction

   // Decode one accepted byte, update the totals and queue whatever results it closes:
   // a word when the 16th byte lands or the SNP ends, then a summary on the last byte.
   function automatic void predict_snp_byte(input logic [BYTE_W-1:0] gbyte,
                                            input logic [MASK_W-1:0] vmask,
                                            input logic swp,
                                            input logic [TAG_W-1:0] tag,
                                            input logic last);
      logic [1:0]  code;
      logic        a1, a2;
      logic [3:0]  p1, p2;
      int          het, hom, pres;
      logic [63:0] n_val, s_val, ss_val, prod, ssq, diff, mean, csq;
      bit          ok;
      result_item_type r;

      het  = 0;
      hom  = 0;
      pres = 0;
      for (int k = 0; k < INDIV_PER_BYTE; k++) begin
         code = gbyte[2*k +: 2];
         case (code)
            CODE_HOM_A: begin a1 = ~swp; a2 = ~swp; end
            CODE_HET:   begin a1 = 1'b0; a2 = 1'b1; end
            CODE_HOM_B: begin a1 = swp;  a2 = swp;  end
            default:    begin a1 = 1'b1; a2 = 1'b0; end   // missing
         endcase
         p1[k] = a1;
         p2[k] = a2;
         if (vmask[k]) begin
            if (!a1 && a2) het++;
            if (a1 && a2) hom++;
            if (!a1 || a2) pres++;
         end
      end
      dose_sum        = clamp_total(dose_sum + het + 2 * hom, SUM_LIMIT);
      dose_square_sum = clamp_total(dose_square_sum + het + 4 * hom, SQUARE_LIMIT);
      present_n       = clamp_total(present_n + pres, COUNT_LIMIT);

      p1_bits |= WORD_W'(p1) << (INDIV_PER_BYTE * slot_pos);
      p2_bits |= WORD_W'(p2) << (INDIV_PER_BYTE * slot_pos);

      if (slot_pos >= SLOT_LAST || last) begin
         r = '{default: '0};
         r.kind        = KIND_WORD;
         r.plane_one   = p1_bits;
         r.plane_two   = p2_bits;
         r.word_number = WNUM_W'(word_seq);
         r.tag         = tag;
         pending_results.push_back(r);
         p1_bits    = '0;
         p2_bits    = '0;
         slot_pos   = 0;
         word_seq   = (word_seq + 1 >= MAX_WORDS_DEF) ? 0 : word_seq + 1;
      end else begin
         slot_pos++;
      end

      if (last) begin
         n_val  = 64'(present_n);
         s_val  = 64'(dose_sum);
         ss_val = 64'(dose_square_sum);
         prod   = n_val * ss_val;
         ssq    = s_val * s_val;
         diff   = (prod > ssq) ? prod - ssq : 64'd0;
         ok     = (n_val != 0) && (2 * diff >= n_val);
         r = '{default: '0};
         r.kind   = KIND_SUMMARY;
         r.tag    = tag;
         r.total  = SUM_W'(dose_sum);
         r.square = SQUARE_W'(dose_square_sum);
         r.last   = 1'b1;
         if (ok) begin
            mean     = (s_val << FRAC_BITS) / n_val;
            csq      = (diff << FRAC_BITS) / n_val;
            r.count  = COUNT_W'(present_n);
            r.mean   = MEAN_W'((mean > MEAN_LIMIT) ? MEAN_LIMIT : mean);
            r.csq    = CSQ_W'((csq > CSQ_LIMIT) ? CSQ_LIMIT : csq);
            r.usable = 1'b1;
         end
         pending_results.push_back(r);
         clear_snp_state();
      end
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // one accepted result item against the oldest expectation
   function automatic void check_response();
      result_item_type want;

      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result item, kind %0d tag %h", $time,
                  rsp_result_kind, rsp_tag_out);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", 64'(want.kind), 64'(rsp_result_kind));
      compare_field("plane_one_word", want.plane_one, rsp_plane_one_word);
      compare_field("plane_two_word", want.plane_two, rsp_plane_two_word);
      compare_field("word_number", 64'(want.word_number), 64'(rsp_word_number));
      compare_field("tag_out", 64'(want.tag), 64'(rsp_tag_out));
      compare_field("present_count", 64'(want.count), 64'(rsp_present_count));
      compare_field("allele_total", 64'(want.total), 64'(rsp_allele_total));
      compare_field("square_total", 64'(want.square), 64'(rsp_square_total));
      compare_field("mean_fixed", 64'(want.mean), 64'(rsp_mean_fixed));
      compare_field("centered_square_fixed", 64'(want.csq),
                    64'(rsp_centered_square_fixed));
      compare_field("usable", 64'(want.usable), 64'(rsp_usable));
      compare_field("last_result", 64'(want.last), 64'(rsp_last_result));
      if (want.kind == KIND_SUMMARY) begin
         summaries_checked++;
         if (want.usable) usable_seen++;
      end else begin
         words_checked++;
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // result side: check at each taken item, then pick pop for the next cycle.
   // A hold request parks pop low for a long hold-off, counted here.
   // ---------------------------------------------------------------------------------
   initial begin : result_side
      int stall_left;
      int hold_left;

      stall_left = 0;
      hold_left  = 0;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) check_response();
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (reset) begin
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            if (stall_left > 0) begin
               stall_left--;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
               stall_left = $urandom_range(1, 8);
            end
            pop <= (stall_left == 0);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // request side: present one item and hold it until the block takes it.
   // push stays high between back-to-back items; it only drops for a gap.
   // ---------------------------------------------------------------------------------
   task automatic send_genotype_byte(input logic [BYTE_W-1:0] gbyte,
                                     input logic [MASK_W-1:0] vmask,
                                     input logic swp,
                                     input logic [TAG_W-1:0] tag,
                                     input logic last);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      push              <= 1'b1;
      req_genotype_byte <= gbyte;
      req_valid_mask    <= vmask;
      req_swap_alleles  <= swp;
      req_snp_tag       <= tag;
      req_last_byte     <= last;
      do begin
         @(posedge clock);
         if (full) full_stall_cycles++;
      end while (full);
      items_sent++;
      predict_snp_byte(gbyte, vmask, swp, tag, last);
   endtask

   // byte flavors: uniform noise, one code everywhere, or homozygotes only
   function automatic logic [BYTE_W-1:0] pick_genotype_byte(input int style);
      logic [BYTE_W-1:0] b;
      logic [1:0]        c;

      b = BYTE_W'($urandom_range(0, 255));
      case (style)
         1: begin
            c = 2'($urandom_range(0, 3));
            b = {INDIV_PER_BYTE{c}};
         end
         2: for (int k = 0; k < INDIV_PER_BYTE; k++)
               b[2*k +: 2] = $urandom_range(0, 1) ? CODE_HOM_A : CODE_HOM_B;
         default: ;
      endcase
      return b;
   endfunction

   // one well-formed SNP with random content; the swap flag normally holds per SNP
   task automatic send_random_snp(input int len);
      logic [TAG_W-1:0]  tag;
      logic              swp;
      bit                mixed_swap;
      bit                full_mask;
      int                style;
      logic [MASK_W-1:0] vmask;

      tag        = TAG_W'($urandom);
      swp        = 1'($urandom_range(0, 1));
      mixed_swap = ($urandom_range(0, 9) == 0);
      full_mask  = ($urandom_range(0, 9) < 6);
      style      = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
         vmask = full_mask ? {MASK_W{1'b1}} : MASK_W'($urandom_range(0, 15));
         if (mixed_swap) swp = 1'($urandom_range(0, 1));
         send_genotype_byte(pick_genotype_byte(style), vmask, swp, tag, i == len - 1);
      end
   endtask

   function automatic int pick_snp_length();
      int r;

      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(1, 20);
      if (r < 88) return $urandom_range(14, 34);    // around one word boundary
      if (r < 98) return $urandom_range(30, 64);
      return $urandom_range(100, 200);
   endfunction

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------

   // one-byte SNPs: every code in both mappings, empty mask, zero spread, the
   // usable threshold hit exactly and missed with a single individual
   task automatic test_code_mapping();
      logic [BYTE_W-1:0] all_codes;

      all_codes = {CODE_HOM_B, CODE_HET, CODE_MISSING, CODE_HOM_A};
      send_genotype_byte(all_codes, 4'hF, 1'b0, 16'h0000, 1'b1);
      send_genotype_byte(all_codes, 4'hF, 1'b1, 16'hFFFF, 1'b1);
      send_genotype_byte({4{CODE_HOM_A}}, 4'h0, 1'b0, 16'h1234, 1'b1);   // count zero
      send_genotype_byte({4{CODE_HOM_A}}, 4'hF, 1'b0, 16'h2345, 1'b1);   // no spread
      send_genotype_byte({4{CODE_MISSING}}, 4'hF, 1'b1, 16'h3456, 1'b1); // all missing
      // dosages 0 and 1: 2*(N*SS - S*S) equals N
      send_genotype_byte({CODE_HOM_A, CODE_HOM_A, CODE_HET, CODE_HOM_B}, 4'h3, 1'b0,
                         16'h4567, 1'b1);
      // single het: spread is zero, one short of the threshold
      send_genotype_byte({CODE_HOM_B, CODE_HOM_B, CODE_HOM_B, CODE_HET}, 4'h1, 1'b1,
                         16'h5678, 1'b1);
   endtask

   // 17 bytes: a full word, then a one-byte partial word; swap flips every byte
   task automatic test_word_packing();
      for (int i = 0; i < 17; i++)
         send_genotype_byte(BYTE_W'($urandom_range(0, 255)), MASK_W'($urandom_range(0, 15)),
                            1'(i % 2), 16'hFFFF, i == 16);
   endtask

   // receiver parks while short SNPs keep coming: summaries pile up and full rises
   task automatic test_queue_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 30; i++) send_random_snp($urandom_range(1, 4));
   endtask

   // One SNP spanning many words: a homozygous, all-valid stretch drives the totals
   // high and the word numbers up; the tail is noise and ends on a partial word.
   task automatic test_long_snp();
      logic [TAG_W-1:0] tag;
      bit               tail;

      tag = TAG_W'($urandom);
      for (int i = 0; i < LONG_SNP_BYTES; i++) begin
         tail = (i >= LONG_SNP_CLEAN);
         send_genotype_byte(tail ? BYTE_W'($urandom_range(0, 255)) : {4{CODE_HOM_A}},
                            tail ? MASK_W'($urandom_range(0, 15)) : 4'hF,
                            tail ? 1'($urandom_range(0, 1)) : 1'b0,
                            tag, i == LONG_SNP_BYTES - 1);
      end
   endtask

   task automatic test_random_snps();
      int stop_at;

      stop_at = items_sent + 500;
      while (items_sent < stop_at) send_random_snp(pick_snp_length());
   endtask

   // last stretch at full rate on both sides
   task automatic test_streaming_no_idle();
      int stop_at;

      idle_enable = 1'b0;
      stop_at = items_sent + 120;
      while (items_sent < stop_at) send_random_snp($urandom_range(1, 40));
   endtask

   initial begin
      errors            = 0;
      items_sent        = 0;
      words_checked     = 0;
      summaries_checked = 0;
      usable_seen       = 0;
      full_stall_cycles = 0;
      idle_enable       = 1'b1;
      hold_request      = 1'b0;
      clear_snp_state();

      reset             = 1'b1;
      push              = 1'b0;
      req_genotype_byte = '0;
      req_valid_mask    = '0;
      req_swap_alleles  = 1'b0;
      req_snp_tag       = '0;
      req_last_byte     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_code_mapping();
      test_word_packing();
      test_queue_backpressure();
      test_long_snp();
      test_random_snps();
      test_streaming_no_idle();
      push <= 1'b0;

      // drain, then give a late or extra result time to show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d bytes in; %0d words, %0d summaries checked (%0d usable)",
               items_sent, words_checked, summaries_checked, usable_seen);
      $display("tb_top: full held the input off for %0d cycles; one SNP of %0d bytes",
               full_stall_cycles, LONG_SNP_BYTES);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
